FILE: rtl/lhagc_pkg.sv
package lhagc_pkg;

    localparam int RING_LEN = 1024;
    localparam int PTR_W = 10;
    localparam int LOOKAHEAD = 288;
    localparam int FAST_LOOKAHEAD = 96;
    localparam logic [17:0] HANG_SAT = 18'h3FFFF;
    localparam logic [15:0] FAST_ATTACK = 16'd6483;
    localparam logic [15:0] FAST_DECAY = 16'd454;

    localparam logic [2:0] REG_AGC_ON = 3'd0;
    localparam logic [2:0] REG_LIMIT = 3'd1;
    localparam logic [2:0] REG_ATTACK = 3'd2;
    localparam logic [2:0] REG_DECAY = 3'd3;
    localparam logic [2:0] REG_SLOPE = 3'd4;
    localparam logic [2:0] REG_GMAX = 3'd5;
    localparam logic [2:0] REG_GMIN = 3'd6;
    localparam logic [2:0] REG_HANG = 3'd7;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SLOW_SQ,
        ST_SLOW_DIV,
        ST_SLOW_SQRT,
        ST_SLOW_UPD,
        ST_SLOW_MUL,
        ST_FAST_RD,
        ST_FAST_SQ,
        ST_FAST_DIV,
        ST_FAST_SQRT,
        ST_FAST_UPD,
        ST_FAST_MUL,
        ST_GAIN,
        ST_OUT_RD,
        ST_SCALE,
        ST_BYPASS,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic start;
        logic [79:0] num;
        logic [47:0] den;
    } div_req_t;

endpackage

FILE: rtl/lhagc_div.sv
module lhagc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lhagc_pkg::div_req_t req,
    output logic              busy,
    output logic [63:0]       quot
);
    import lhagc_pkg::*;

    logic [79:0] num_reg;
    logic [80:0] rem_reg;
    logic [47:0] den_reg;
    logic [6:0]  cnt_reg;
    logic [80:0] trial;

    assign trial = {rem_reg[79:0], num_reg[79]};
    assign busy = (cnt_reg != 7'd0);
    assign quot = num_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else if (req.start)
        begin
            cnt_reg <= 7'd80;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            if (trial >= {33'd0, den_reg})
            begin
                rem_reg <= trial - {33'd0, den_reg};
                num_reg <= {num_reg[78:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[78:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/lhagc_sqrt.sv
module lhagc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);
    import lhagc_pkg::*;

    logic [63:0] val_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] trial;
    logic [33:0] sub;

    assign busy = (cnt_reg != 6'd0);
    assign root = root_reg;
    assign trial = {rem_reg[31:0], val_reg[63:62]};
    assign sub = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy)
        begin
            val_reg <= {val_reg[61:0], 2'b00};
            if (trial >= sub)
            begin
                rem_reg <= trial - sub;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/lookahead_hang_agc.sv
// With the AGC running, each request goes through two 80-step divisions and two 32-step
// square roots in shared serial units; a zero-magnitude sample skips its division and root.
// With the AGC off the sample bypasses them. A new request is taken only after the last
// result has been accepted, so result stalls hold off further requests.
// Reset: asynchronous, active low. After reset a clearing pass writes
// zeros to all ring entries, one a cycle, before the first request is taken.
module lookahead_hang_agc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_i [15:0], sample_q [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_i [15:0], out_q [31:16]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lhagc_pkg::*;

    logic        agc_on_reg;
    logic [14:0] limit_reg;
    logic [15:0] attack_reg, decay_reg, slope_reg;
    logic [31:0] gmax_reg, gmin_reg;
    logic [17:0] hang_reg;

    state_t state_reg, state_next;
    logic [31:0] ring [RING_LEN];
    logic [PTR_W-1:0] wp_reg, clr_reg, raddr;
    logic [31:0] rdata_reg, word_reg, in_reg;
    logic [31:0] slow_reg, fast_reg, cand_reg, g_reg;
    logic [17:0] shang_reg, fhang_reg;
    logic [31:0] outw_reg;
    logic [63:0] prod_reg, prod2_reg;
    logic        zero_reg;
    logic        ring_we;
    logic [PTR_W-1:0] waddr;
    logic [31:0] wdata;

    div_req_t dreq;
    logic div_busy, sq_busy, sq_start;
    logic [63:0] quot;
    logic [31:0] root;

    logic signed [16:0] mi, mq;
    logic signed [31:0] ii, qq;
    logic signed [33:0] m2_c;
    logic [31:0] cand;
    logic signed [49:0] thresh, thresh_reg;
    logic        cand_low;
    logic [17:0] shang_base;
    logic [31:0] dabs;
    logic [63:0] hprod;
    logic [31:0] tgt, ga, gb, sm, fast_hang_lim;
    logic [15:0] coef;
    logic [16:0] ncoef;
    logic [31:0] clamp_s, clamp_f, slp;
    logic [47:0] slp_w;
    logic signed [48:0] pi_w, pq_w;
    logic [15:0] oi, oq;

    function automatic logic [15:0] scale16(input logic signed [48:0] p);
        logic signed [48:0] r;
        r = (p + 49'sd32768) >>> 16;
        if (r > 49'sd32767) return 16'h7FFF;
        else if (r < -49'sd32768) return 16'h8000;
        else return r[15:0];
    endfunction

    function automatic logic [15:0] sat10(input logic [15:0] s);
        logic signed [20:0] p;
        p = $signed(s) * 21'sd10;
        if (p > 21'sd32767) return 16'h7FFF;
        else if (p < -21'sd32768) return 16'h8000;
        else return p[15:0];
    endfunction

    lhagc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(div_busy), .quot(quot));
    lhagc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(quot),
                       .busy(sq_busy), .root(root));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agc_on_reg <= 1'b1;
            limit_reg <= 15'd16384;
            attack_reg <= 16'd2000;
            decay_reg <= 16'd200;
            slope_reg <= 16'd256;
            gmax_reg <= 32'h8000_0000;
            gmin_reg <= 32'h0001_0000;
            hang_reg <= 18'd12000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AGC_ON: agc_on_reg <= cfg_data[0];
                REG_LIMIT:  limit_reg <= cfg_data[14:0];
                REG_ATTACK: attack_reg <= cfg_data[15:0];
                REG_DECAY:  decay_reg <= cfg_data[15:0];
                REG_SLOPE:  slope_reg <= cfg_data[15:0];
                REG_GMAX:   gmax_reg <= cfg_data;
                REG_GMIN:   gmin_reg <= cfg_data;
                REG_HANG:   hang_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Squared magnitude and candidate gain from the word under work.
    assign mi = {word_reg[15], word_reg[15:0]};
    assign mq = {word_reg[31], word_reg[31:16]};
    assign ii = mi * mi;
    assign qq = mq * mq;
    assign m2_c = 34'(ii) + 34'(qq);
    assign cand = zero_reg ? ((state_reg == ST_SLOW_UPD) ? slow_reg : fast_reg) : root;

    assign dabs = (gmax_reg >= gmin_reg) ? gmax_reg - gmin_reg : gmin_reg - gmax_reg;
    assign hprod = gmin_reg * dabs;
    always_comb
    begin
        if (gmin_reg == 32'd0)
            thresh = '0;
        else if (gmax_reg >= gmin_reg)
            thresh = $signed({18'd0, gmin_reg}) + $signed({2'b00, hprod[63:16]});
        else
            thresh = $signed({18'd0, gmin_reg}) - $signed({2'b00, hprod[63:16]});
    end
    assign cand_low = $signed({18'd0, cand}) < thresh_reg;
    assign shang_base = cand_low ? hang_reg : shang_reg;
    assign fast_hang_lim = 32'((36'(hang_reg) * 36'd52429) >> 19);

    // Smoothing operands, clamps, slope limit and output scaling; the multiply runs in the *_UPD state, sum in *_MUL.
    assign ncoef = 17'h10000 - {1'b0, coef};
    assign sm = 32'((prod_reg + prod2_reg + 64'd32768) >> 16);
    assign clamp_s = (slow_reg > gmax_reg) ? gmax_reg : slow_reg;
    assign clamp_f = (fast_reg > gmax_reg) ? gmax_reg : fast_reg;
    assign slp_w = slope_reg * g_reg;
    assign slp = (slp_w[47:8] < {8'd0, gmax_reg}) ? slp_w[39:8] : gmax_reg;
    assign pi_w = $signed(rdata_reg[15:0]) * $signed({1'b0, g_reg});
    assign pq_w = $signed(rdata_reg[31:16]) * $signed({1'b0, g_reg});
    assign oi = scale16(pi_w);
    assign oq = scale16(pq_w);

    always_comb
    begin
        tgt = '0;
        coef = '0;
        ga = '0;
        unique case (state_reg)
            ST_SLOW_UPD:
            begin
                ga = slow_reg;
                if (cand >= slow_reg)
                begin
                    tgt = (cand < gmax_reg) ? cand : gmax_reg;
                    coef = decay_reg;
                end
                else
                begin
                    tgt = (cand > gmin_reg) ? cand : gmin_reg;
                    coef = attack_reg;
                end
            end
            ST_FAST_UPD:
            begin
                ga = fast_reg;
                if (cand > fast_reg)
                begin
                    tgt = (cand < gmax_reg) ? cand : gmax_reg;
                    coef = FAST_DECAY;
                end
                else
                begin
                    tgt = (cand > gmin_reg) ? cand : gmin_reg;
                    coef = FAST_ATTACK;
                end
            end
            default: ;
        endcase
    end
    assign gb = tgt;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_reg == PTR_W'(RING_LEN - 1)) state_next = ST_IDLE;
            ST_IDLE:      if (s_tvalid) state_next = agc_on_reg ? ST_WRITE : ST_BYPASS;
            ST_WRITE:     state_next = ST_SLOW_SQ;
            ST_SLOW_SQ:   state_next = ST_SLOW_DIV;
            ST_SLOW_DIV:  if (!div_busy) state_next = ST_SLOW_SQRT;
            ST_SLOW_SQRT: if (!sq_busy) state_next = ST_SLOW_UPD;
            ST_SLOW_UPD:  state_next = ST_SLOW_MUL;
            ST_SLOW_MUL:  state_next = ST_FAST_RD;
            ST_FAST_RD:   state_next = ST_FAST_SQ;
            ST_FAST_SQ:   state_next = ST_FAST_DIV;
            ST_FAST_DIV:  if (!div_busy) state_next = ST_FAST_SQRT;
            ST_FAST_SQRT: if (!sq_busy) state_next = ST_FAST_UPD;
            ST_FAST_UPD:  state_next = ST_FAST_MUL;
            ST_FAST_MUL:  state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_OUT_RD;
            ST_OUT_RD:    state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_SEND;
            ST_BYPASS:    state_next = ST_SEND;
            ST_SEND:      if (m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_SEND);
        m_tdata = outw_reg;
        ring_we = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        waddr = (state_reg == ST_CLEAR) ? clr_reg : wp_reg;
        wdata = (state_reg == ST_CLEAR) ? 32'd0 : in_reg;
        raddr = (state_reg == ST_OUT_RD || state_reg == ST_GAIN)
              ? wp_reg + PTR_W'(LOOKAHEAD) : wp_reg + PTR_W'(FAST_LOOKAHEAD);
        dreq.start = (state_reg == ST_SLOW_SQ || state_reg == ST_FAST_SQ) && (m2_c != '0);
        dreq.num = {1'b0, 30'(limit_reg) * 30'(limit_reg), 49'd0} >> 17;
        dreq.den = 48'(m2_c);
        sq_start = (state_reg == ST_SLOW_DIV || state_reg == ST_FAST_DIV) && !div_busy
                   && !zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[waddr] <= wdata;
        rdata_reg <= ring[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            wp_reg <= '0;
            slow_reg <= 32'h0001_0000;
            fast_reg <= 32'h0001_0000;
            shang_reg <= '0;
            fhang_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + PTR_W'(1);
            if (state_reg == ST_SLOW_UPD)
            begin
                if (cand >= slow_reg)
                begin
                    if (shang_base != HANG_SAT)
                        shang_reg <= shang_base + 18'd1;
                    else
                        shang_reg <= shang_base;
                end
                else
                    shang_reg <= '0;
            end
            if (state_reg == ST_SLOW_MUL)
                slow_reg <= (cand_reg == 32'd1) ? sm : slow_reg;
            if (state_reg == ST_FAST_UPD)
            begin
                if (cand > fast_reg)
                begin
                    if (fhang_reg != HANG_SAT)
                        fhang_reg <= fhang_reg + 18'd1;
                end
                else
                    fhang_reg <= '0;
            end
            if (state_reg == ST_FAST_MUL)
            begin
                if (cand_reg == 32'd1)
                    fast_reg <= (sm > gmax_reg && !g_reg[0]) ? gmax_reg
                              : (sm < gmin_reg && g_reg[0]) ? gmin_reg : sm;
            end
            if (state_reg == ST_GAIN)
            begin
                fast_reg <= (clamp_f < gmin_reg) ? gmin_reg : clamp_f;
                slow_reg <= (clamp_s < gmin_reg) ? gmin_reg : clamp_s;
            end
            if (state_reg == ST_SEND && m_tready && agc_on_reg)
                wp_reg <= wp_reg - PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        thresh_reg <= thresh;
        if (s_tvalid && s_tready)
            in_reg <= s_tdata;
        unique case (state_reg)
            ST_WRITE:   word_reg <= in_reg;
            ST_FAST_RD: word_reg <= rdata_reg;
            default: ;
        endcase
        if (state_reg == ST_SLOW_SQ || state_reg == ST_FAST_SQ)
            zero_reg <= (m2_c == '0);
        if (state_reg == ST_SLOW_UPD || state_reg == ST_FAST_UPD)
        begin
            prod_reg <= 64'(ncoef) * 64'(ga);
            prod2_reg <= 64'(coef) * 64'(gb);
            // Flag whether the smoothed value is taken, and which clamp applies.
            if (state_reg == ST_SLOW_UPD)
                cand_reg <= (cand < slow_reg || (!cand_low && shang_reg > hang_reg))
                            ? 32'd1 : 32'd0;
            else
            begin
                cand_reg <= (cand <= fast_reg || 32'(fhang_reg) > fast_hang_lim)
                            ? 32'd1 : 32'd0;
                g_reg <= {31'd0, cand <= fast_reg};
            end
        end
        if (state_reg == ST_GAIN)
            g_reg <= (clamp_s < gmin_reg) ? gmin_reg : clamp_s;
        if (state_reg == ST_OUT_RD)
            g_reg <= (fast_reg < slp) ? fast_reg : slp;
        if (state_reg == ST_SCALE)
            outw_reg <= {oq, oi};
        if (state_reg == ST_BYPASS)
            outw_reg <= {sat10(in_reg[31:16]), sat10(in_reg[15:0])};
    end
endmodule

FILE: rtl/lhagc_checker.sv
module lhagc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after request");
endmodule

bind lookahead_hang_agc lhagc_checker u_chk (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

import lhagc_pkg::*;

class agc_scoreboard;
    bit [31:0] expected_q[$];
    int        errors;

    bit        agc_on;
    bit [14:0] gain_limit;
    bit [15:0] attack_coef, decay_coef, slope;
    bit [31:0] gain_max, gain_min;
    bit [17:0] hang_samples;

    bit [31:0] ring[RING_LEN];
    bit [PTR_W-1:0] wp;
    bit [31:0] slow_gain, fast_gain;
    bit [17:0] slow_hang, fast_hang;

    function new();
        agc_on = 1'b1;
        gain_limit = 15'd16384;
        attack_coef = 16'd2000;
        decay_coef = 16'd200;
        slope = 16'd256;
        gain_max = 32'h8000_0000;
        gain_min = 32'd65536;
        hang_samples = 18'd12000;
        foreach (ring[k]) ring[k] = '0;
        wp = '0;
        slow_gain = 32'd65536;
        fast_gain = 32'd65536;
        slow_hang = '0;
        fast_hang = '0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_AGC_ON: agc_on = val[0];
            REG_LIMIT:  gain_limit = val[14:0];
            REG_ATTACK: attack_coef = val[15:0];
            REG_DECAY:  decay_coef = val[15:0];
            REG_SLOPE:  slope = val[15:0];
            REG_GMAX:   gain_max = val;
            REG_GMIN:   gain_min = val;
            REG_HANG:   hang_samples = val[17:0];
            default:    ;
        endcase
    endfunction

    function bit [15:0] sat16(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function bit [63:0] root64(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function bit [31:0] target_gain(bit [31:0] w, bit [31:0] cur);
        longint    i, q;
        bit [63:0] m2, l2;
        i = longint'(signed'(w[15:0]));
        q = longint'(signed'(w[31:16]));
        m2 = i * i + q * q;
        if (m2 == 0) return cur;
        l2 = 64'(gain_limit) * 64'(gain_limit);
        return 32'(root64((l2 << 32) / m2));
    endfunction

    function bit [31:0] smooth(bit [31:0] g, bit [31:0] x, bit [15:0] a);
        bit [63:0] s;
        s = (64'd65536 - 64'(a)) * 64'(g) + 64'(a) * 64'(x) + 64'd32768;
        return 32'(s >> 16);
    endfunction

    function bit [31:0] umin(bit [31:0] a, bit [31:0] b);
        return a < b ? a : b;
    endfunction

    function bit [31:0] umax(bit [31:0] a, bit [31:0] b);
        return a > b ? a : b;
    endfunction

    function bit [15:0] apply_gain(bit [15:0] s, bit [31:0] g);
        longint p;
        p = longint'(signed'(s)) * longint'({32'd0, g}) + 32768;
        return sat16(p >>> 16);
    endfunction

    function void log_sample(bit [15:0] si, bit [15:0] sq);
        longint    thresh, part;
        bit [63:0] d, sl;
        bit [31:0] top, bot, cand, w, g;
        bit [17:0] old;
        if (!agc_on) begin
            expected_q.push_back({sat16(longint'(signed'(sq)) * 10),
                                  sat16(longint'(signed'(si)) * 10)});
            return;
        end
        top = gain_max;
        bot = gain_min;
        thresh = 0;
        if (gain_min != 0) begin
            d = top >= bot ? 64'(top - bot) : 64'(bot - top);
            part = longint'((64'(gain_min) * d) >> 16);
            thresh = top >= bot ? longint'({32'd0, bot}) + part
                                : longint'({32'd0, bot}) - part;
        end
        ring[wp] = {sq, si};

        cand = target_gain(ring[wp], slow_gain);
        if (longint'({32'd0, cand}) < thresh) slow_hang = hang_samples;
        if (cand >= slow_gain) begin
            old = slow_hang;
            if (slow_hang < HANG_SAT) slow_hang++;
            if (old > hang_samples)
                slow_gain = smooth(slow_gain, umin(top, cand), decay_coef);
        end else begin
            slow_hang = '0;
            slow_gain = smooth(slow_gain, umax(cand, bot), attack_coef);
        end

        w = ring[PTR_W'(wp + FAST_LOOKAHEAD)];
        cand = target_gain(w, fast_gain);
        if (cand > fast_gain) begin
            old = fast_hang;
            if (fast_hang < HANG_SAT) fast_hang++;
            if (old > hang_samples / 10)
                fast_gain = umin(smooth(fast_gain, umin(top, cand), FAST_DECAY), top);
        end else begin
            fast_hang = '0;
            fast_gain = umax(smooth(fast_gain, umax(cand, bot), FAST_ATTACK), bot);
        end

        fast_gain = umax(umin(fast_gain, top), bot);
        slow_gain = umax(umin(slow_gain, top), bot);
        sl = (64'(slope) * 64'(slow_gain)) >> 8;
        g = umin(fast_gain, sl < 64'(top) ? 32'(sl) : top);
        w = ring[PTR_W'(wp + LOOKAHEAD)];
        expected_q.push_back({apply_gain(w[31:16], g), apply_gain(w[15:0], g)});
        wp = wp - 1'b1;
    endfunction

    function void check_output(bit [31:0] data);
        bit [31:0] exp_word;
        if (expected_q.size() == 0) begin
            $error("unexpected output %h", data);
            errors++;
            return;
        end
        exp_word = expected_q.pop_front();
        if (data[15:0] !== exp_word[15:0]) begin
            $error("out_i expected %0d actual %0d",
                   signed'(exp_word[15:0]), signed'(data[15:0]));
            errors++;
        end
        if (data[31:16] !== exp_word[31:16]) begin
            $error("out_q expected %0d actual %0d",
                   signed'(exp_word[31:16]), signed'(data[31:16]));
            errors++;
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    agc_scoreboard agc_sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;

    lookahead_hang_agc u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // The receiver side; a hold-off keeps m_tready low for a long stretch.
    initial
    begin
        int held;
        held = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
            end
            if (held > 0)
            begin
                held--;
                m_tready = 1'b0;
            end
            else
            begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            agc_sb.check_output(m_tdata);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        agc_sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_sample(logic [15:0] si, logic [15:0] sq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {sq, si};
        do
            @(posedge clk);
        while (!s_tready);
        agc_sb.log_sample(si, sq);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_outputs();
        while (agc_sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic apply_setting(int k);
        case (k)
            0:
            begin
                write_reg(REG_AGC_ON, 32'd1);
                write_reg(REG_LIMIT, 32'd16384);
                write_reg(REG_ATTACK, 32'd2000);
                write_reg(REG_DECAY, 32'd200);
                write_reg(REG_SLOPE, 32'd256);
                write_reg(REG_GMAX, 32'h8000_0000);
                write_reg(REG_GMIN, 32'd65536);
                write_reg(REG_HANG, 32'd12000);
            end
            1: write_reg(REG_AGC_ON, 32'd0);
            2:
            begin
                write_reg(REG_AGC_ON, 32'd1);
                write_reg(REG_LIMIT, 32'd32767);
                write_reg(REG_ATTACK, 32'd65535);
                write_reg(REG_DECAY, 32'd65535);
                write_reg(REG_SLOPE, 32'd65535);
                write_reg(REG_HANG, 32'd0);
            end
            3:
            begin
                write_reg(REG_LIMIT, 32'd0);
                write_reg(REG_ATTACK, 32'd0);
                write_reg(REG_DECAY, 32'd0);
                write_reg(REG_SLOPE, 32'd0);
            end
            4:
            begin
                write_reg(REG_LIMIT, 32'd1000);
                write_reg(REG_ATTACK, 32'd2000);
                write_reg(REG_DECAY, 32'd200);
                write_reg(REG_SLOPE, 32'd256);
                write_reg(REG_GMAX, 32'hFFFF_FFFF);
                write_reg(REG_GMIN, 32'd0);
                write_reg(REG_HANG, 32'd262143);
            end
            // Inverted clamps: both gains pin to the lower limit.
            5:
            begin
                write_reg(REG_GMAX, 32'd65536);
                write_reg(REG_GMIN, 32'h0020_0000);
            end
            6:
            begin
                write_reg(REG_GMAX, 32'hFFFF_FFFF);
                write_reg(REG_GMIN, 32'hFFFF_FFFF);
            end
            7:
            begin
                write_reg(REG_GMAX, 32'd0);
                write_reg(REG_GMIN, 32'd0);
            end
            8:
            begin
                write_reg(REG_LIMIT, 32'd8000);
                write_reg(REG_SLOPE, 32'd512);
                write_reg(REG_GMAX, 32'h0100_0000);
                write_reg(REG_GMIN, 32'h0000_8000);
                write_reg(REG_HANG, 32'd50);
                write_reg(REG_ATTACK, 32'd30000);
                write_reg(REG_DECAY, 32'd5000);
            end
            default:
            begin
                logic [31:0] lo, hi;
                lo = $urandom_range(32'h0004_0000);
                hi = lo + $urandom_range(32'h0400_0000);
                if ($urandom_range(7) == 0)
                    hi = $urandom;
                write_reg(REG_AGC_ON, 32'($urandom_range(5) != 0));
                write_reg(REG_LIMIT, $urandom_range(32767));
                write_reg(REG_ATTACK, $urandom_range(65535));
                write_reg(REG_DECAY, $urandom_range(65535));
                write_reg(REG_SLOPE, $urandom_range(1024));
                write_reg(REG_GMAX, hi);
                write_reg(REG_GMIN, lo);
                write_reg(REG_HANG, $urandom_range(300));
            end
        endcase
    endtask

    initial
    begin
        logic [15:0] di[11] = '{16'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'd1, 16'd0,
                                16'd100, 16'h7FFF, 16'd3276, 16'd3277, 16'd0};
        logic [15:0] dq[11] = '{16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF,
                                16'hFF9C, 16'h8000, 16'hF333, 16'd0, 16'd0};
        int seg_left, amp, n;
        logic [15:0] si, sq;

        agc_sb = new();
        send_idle_pct = 22;
        recv_idle_pct = 87;
        hold_request = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        apply_setting(0);
        for (int k = 0; k < 7; k++)
            send_sample(di[k], dq[k]);
        drain_outputs();
        apply_setting(1);
        for (int k = 7; k < 11; k++)
            send_sample(di[k], dq[k]);
        drain_outputs();

        amp = 0;
        seg_left = 0;
        for (int s = 0; s < 15; s++)
        begin
            if (s == 5)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 22;
            end
            if (s == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(s == 1 ? 1 : (s == 0 ? 0 : s));
            n = (s == 0) ? 60 : 68;
            for (int k = 0; k < n; k++)
            begin
                if (s == 11 && k == 5)
                    hold_request = 3000;
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(40, 1);
                    amp = (1 << $urandom_range(15)) - 1;
                    if ($urandom_range(5) == 0)
                        amp = 0;
                end
                seg_left--;
                if ($urandom_range(9) == 0)
                begin
                    si = $urandom;
                    sq = $urandom;
                end
                else
                begin
                    si = 16'($urandom_range(2 * amp) - amp);
                    sq = 16'($urandom_range(2 * amp) - amp);
                end
                send_sample(si, sq);
            end
            drain_outputs();
        end

        repeat (300) @(negedge clk);
        if (agc_sb.errors == 0 && agc_sb.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: lookahead_hang_agc.f
rtl/lhagc_pkg.sv
rtl/lhagc_div.sv
rtl/lhagc_sqrt.sv
rtl/lookahead_hang_agc.sv
rtl/lhagc_checker.sv
bench/tb.sv
